// ===== rtl/stoi_pkg.sv =====
// Shared constants and character helpers for the string to integer parser.
package stoi_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned CH_W            = 8;
  localparam int unsigned VAL_W           = 64;
  localparam int unsigned CONS_W          = 16;
  localparam int unsigned STAT_W          = 2;
  localparam int unsigned BASE_W          = 6;
  localparam int unsigned MAC_W           = VAL_W + BASE_W;
  localparam int unsigned OUT_DATA_W      = 88;
  localparam int unsigned CFG_ADDR_W      = 5;
  localparam int unsigned CFG_DATA_W      = 64;

  localparam logic [CONS_W-1:0] CONS_MAX = '1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_LOWER = 2'd1;
  localparam logic [1:0] REG_UPPER = 2'd2;

  localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0] NO_DIGIT   = 6'd36;

  localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CH_W-1:0] CH_CR    = 8'd13;
  localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UX    = 8'h58;
  localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LX    = 8'h78;
  localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;

  function automatic logic [BASE_W-1:0] digit_value(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] t;
    t = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      t = c - CH_UA + 8'd10;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      t = c - CH_LA + 8'd10;
    end else begin
      t = CH_W'(NO_DIGIT);
    end
    return t[BASE_W-1:0];
  endfunction

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
  endfunction

endpackage

// ===== rtl/string_to_integer_parser.sv =====
// Streaming strtoll-style parser: one character per cycle in, one result per string out.
// Takes one character per clock cycle, sustained, as long as results are drained. A
// character is held in an input register, then one pass of logic (digit decode, a
// 64x6 multiply-add and an exact compare against the magnitude limit) updates the parse
// state and loads the result register as the terminating character leaves the input
// register, held while a result waits. The character-to-character dependence through the
// running total is that single multiply-add and compare. Configuration is sampled when
// a string starts (base) and when its sign is resolved (bounds); write it only while idle.
module string_to_integer_parser
  import stoi_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [CH_W-1:0]       in_tdata,    // [7:0] ch
  input  logic                  in_tuser,    // [0] first
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [63:0] value, [79:64] consumed, [81:80] status
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEAD, PH_START, PH_ZERO, PH_HEX, PH_DIGITS, PH_DONE
  } phase_t;

  logic [BASE_W-1:0]      base_r;
  logic [VAL_W-1:0]       lower_r;
  logic [VAL_W-1:0]       upper_r;

  logic                   in_valid_r;
  logic [CH_W-1:0]        ch_r;
  logic                   first_r;

  phase_t                 ph_r, ph_nxt, cur_ph;
  logic                   neg_r, neg_nxt, cur_neg;
  logic [BASE_W-1:0]      ab_r, ab_nxt, cur_ab;
  logic [VAL_W-1:0]       tot_r, tot_nxt, cur_tot;
  logic [VAL_W-1:0]       lim_r, lim_nxt, cur_lim;
  logic                   rf_r, rf_nxt, cur_rf;
  logic [COUNT_WIDTH-1:0] pos_r, pos_nxt, cur_pos;

  logic                   out_valid_r;
  logic [VAL_W-1:0]       res_value_r, res_value;
  logic [CONS_W-1:0]      res_cnt_r, res_cnt;
  logic [STAT_W-1:0]      res_status_r, res_status;
  logic                   res_hit;

  logic                   adv;
  logic                   cfg_wr;
  logic [BASE_W-1:0]      dig;
  logic                   live;
  logic                   do_take;
  logic                   take_in_digits;
  logic [MAC_W-1:0]       mac;
  logic [VAL_W-1:0]       lim_neg;
  logic [COUNT_WIDTH-1:0] cnt_sel;
  logic [32:0]            cnt_ext;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= BASE_DEC;
      lower_r <= {1'b1, {(VAL_W-1){1'b0}}};
      upper_r <= {1'b0, {(VAL_W-1){1'b1}}};
    end else if (cfg_wr) begin
      case (cfg_paddr[4:3])
        REG_BASE:  base_r  <= cfg_pwdata[BASE_W-1:0];
        REG_LOWER: lower_r <= cfg_pwdata;
        REG_UPPER: upper_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:3])
      REG_BASE:  cfg_prdata = CFG_DATA_W'(base_r);
      REG_LOWER: cfg_prdata = lower_r;
      REG_UPPER: cfg_prdata = upper_r;
      default:   cfg_prdata = '0;
    endcase
  end

  assign adv       = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      ch_r    <= in_tdata;
      first_r <= in_tuser;
    end
  end

  assign dig     = digit_value(ch_r);
  assign lim_neg = lower_r[VAL_W-1] ? (VAL_W'(0) - lower_r) : upper_r;

  always_comb begin
    cur_ph  = ph_r;
    cur_neg = neg_r;
    cur_ab  = ab_r;
    cur_tot = tot_r;
    cur_lim = lim_r;
    cur_rf  = rf_r;
    cur_pos = pos_r;
    live    = 1'b1;
    if (first_r) begin
      cur_ph  = PH_LEAD;
      cur_neg = 1'b0;
      cur_ab  = base_r;
      cur_tot = '0;
      cur_lim = '0;
      cur_rf  = 1'b0;
      cur_pos = '0;
    end else if (ph_r == PH_IDLE || ph_r == PH_DONE) begin
      live = 1'b0;
    end

    ph_nxt         = cur_ph;
    neg_nxt        = cur_neg;
    ab_nxt         = cur_ab;
    tot_nxt        = cur_tot;
    lim_nxt        = cur_lim;
    rf_nxt         = cur_rf;
    pos_nxt        = cur_pos;
    res_hit        = 1'b0;
    res_value      = '0;
    cnt_sel        = '0;
    res_status     = ST_OK;
    do_take        = 1'b0;
    take_in_digits = 1'b0;
    mac            = '0;

    if (first_r && (base_r == BASE_ONE || base_r > BASE_MAX)) begin
      live       = 1'b0;
      res_hit    = 1'b1;
      res_status = ST_INVALID;
      ph_nxt     = PH_DONE;
    end

    if (live) begin
      case (cur_ph)
        PH_LEAD: begin
          if (is_space(ch_r)) begin
            ph_nxt = PH_LEAD;
          end else if (ch_r == CH_MINUS || ch_r == CH_PLUS) begin
            neg_nxt = (ch_r == CH_MINUS);
            lim_nxt = (ch_r == CH_MINUS) ? lim_neg : upper_r;
            ph_nxt  = PH_START;
          end else begin
            lim_nxt = cur_neg ? lim_neg : upper_r;
            if ((cur_ab == BASE_AUTO || cur_ab == BASE_HEX) && ch_r == CH_ZERO) begin
              ph_nxt = PH_ZERO;
            end else begin
              if (cur_ab == BASE_AUTO) ab_nxt = BASE_DEC;
              do_take = 1'b1;
            end
          end
        end
        PH_START: begin
          if ((cur_ab == BASE_AUTO || cur_ab == BASE_HEX) && ch_r == CH_ZERO) begin
            ph_nxt = PH_ZERO;
          end else begin
            if (cur_ab == BASE_AUTO) ab_nxt = BASE_DEC;
            do_take = 1'b1;
          end
        end
        PH_ZERO: begin
          if (ch_r == CH_LX || ch_r == CH_UX) begin
            ab_nxt = BASE_HEX;
            ph_nxt = PH_HEX;
          end else begin
            if (cur_ab == BASE_AUTO) ab_nxt = BASE_OCT;
            do_take        = 1'b1;
            take_in_digits = 1'b1;
          end
        end
        PH_HEX: begin
          if (dig < BASE_HEX) begin
            do_take = 1'b1;
          end else begin
            res_hit = 1'b1;
            cnt_sel = (cur_pos != '0) ? cur_pos - 1'b1 : '0;
            ph_nxt  = PH_DONE;
          end
        end
        PH_DIGITS: begin
          do_take        = 1'b1;
          take_in_digits = 1'b1;
        end
        default: ;
      endcase

      if (do_take) begin
        if (dig < ab_nxt) begin
          mac = MAC_W'(cur_tot) * MAC_W'(ab_nxt) + MAC_W'(dig);
          if (!cur_rf) begin
            if (mac > MAC_W'(lim_nxt)) begin
              tot_nxt = lim_nxt;
              rf_nxt  = 1'b1;
            end else begin
              tot_nxt = mac[VAL_W-1:0];
            end
          end
          ph_nxt = PH_DIGITS;
        end else if (take_in_digits) begin
          res_hit    = 1'b1;
          res_value  = neg_nxt ? (VAL_W'(0) - cur_tot) : cur_tot;
          cnt_sel    = cur_pos;
          res_status = cur_rf ? ST_RANGE : ST_OK;
          ph_nxt     = PH_DONE;
        end else begin
          res_hit    = 1'b1;
          res_status = ST_INVALID;
          ph_nxt     = PH_DONE;
        end
      end

      if (cur_pos != '1) pos_nxt = cur_pos + 1'b1;
    end

    cnt_ext = 33'(cnt_sel);
    res_cnt = (cnt_ext > 33'(CONS_MAX)) ? CONS_MAX : cnt_ext[CONS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_IDLE;
      neg_r <= 1'b0;
      ab_r  <= BASE_DEC;
      tot_r <= '0;
      lim_r <= '0;
      rf_r  <= 1'b0;
      pos_r <= '0;
    end else if (adv) begin
      ph_r  <= ph_nxt;
      neg_r <= neg_nxt;
      ab_r  <= ab_nxt;
      tot_r <= tot_nxt;
      lim_r <= lim_nxt;
      rf_r  <= rf_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_tready || !out_valid_r) begin
      out_valid_r <= adv & res_hit;
    end
    if (adv && res_hit) begin
      res_value_r  <= res_value;
      res_cnt_r    <= res_cnt;
      res_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, res_status_r, res_cnt_r, res_value_r};

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_status_r == ST_INVALID |-> res_value_r == '0 && res_cnt_r == '0)
    else $error("invalid result carries a value or count");

  a_clamp_holds_limit: assert property (@(posedge clk) disable iff (!rst_n)
    rf_r |-> tot_r == lim_r)
    else $error("range flag set but total is not the limit");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without a blocked result");

endmodule
